>>> rtl/core/tof_pkg.sv
// shared constants and types of the telnet option filter
package tof_pkg;

  // hold store geometry
  localparam int HOLD_DEPTH = 32;
  localparam int ADDR_W     = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

  // telnet protocol bytes
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_SE   = 8'hF0;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  // option number after reset
  localparam logic [7:0] OPT_RESET = 8'd201;

  // what the immediate part of a request produces
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_DATA,
    JOB_REPLY
  } job_kind_t;

  // one classified request, handed from front to back
  typedef struct packed {
    job_kind_t        jkind;
    logic [7:0]       data;       // data byte, or option byte of a reply
    logic             reply_do;   // reply middle byte is DO, else WILL
    logic             buf_end;    // append buffer end marker
    logic [CNT_W-1:0] flush_cnt;  // held bytes to hand on before the marker
    logic             option_on;
    logic             ovf;
  } job_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       option_on;
    logic       ovf;
    logic       last;
  } result_t;

  // hold store write from the front
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } hold_wr_t;

endpackage

>>> rtl/core/tof_front.sv
// front end: telnet sequence parser, option tracking and request classification
module tof_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  input  logic                buffer_end,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  logic                jq_full,
  input  logic                flush_done,
  output logic                job_push,
  output tof_pkg::job_t       job,
  output tof_pkg::hold_wr_t   hold_wr
);

  typedef enum logic [4:0] {
    PH_NORMAL  = 5'b00001,
    PH_IAC     = 5'b00010,
    PH_CMD     = 5'b00100,
    PH_SUB     = 5'b01000,
    PH_SUB_IAC = 5'b10000
  } phase_t;

  phase_t                      phase, phase_next;
  logic [7:0]                  held_cmd, held_cmd_next;
  logic                        opt_en, opt_en_next;
  logic [tof_pkg::CNT_W-1:0]   hold_cnt, hold_cnt_next;
  logic                        ovf_seen, ovf_seen_next;
  logic [7:0]                  option_code;
  logic                        flush_busy;

  logic                        accept;
  logic                        put;
  logic                        room;
  logic                        ovf_work;
  logic [tof_pkg::CNT_W-1:0]   put_base;
  logic [tof_pkg::CNT_W-1:0]   flush_cnt;
  tof_pkg::job_kind_t          jkind;
  logic [7:0]                  jdata;
  logic                        jdo;

  // hold off while the queue is full or a flush reads the hold store
  assign full   = jq_full | flush_busy;
  assign accept = push & ~full;

  // per-byte phase machine
  always_comb begin
    phase_next    = phase;
    held_cmd_next = held_cmd;
    opt_en_next   = opt_en;
    hold_cnt_next = hold_cnt;
    put           = 1'b0;
    put_base      = hold_cnt;
    jkind         = tof_pkg::JOB_NONE;
    jdata         = in_byte;
    jdo           = 1'b0;
    unique case (phase)
      PH_IAC: begin
        if (in_byte == tof_pkg::B_IAC) begin
          jkind         = tof_pkg::JOB_DATA;
          jdata         = tof_pkg::B_IAC;
          hold_cnt_next = '0;
          phase_next    = PH_NORMAL;
        end else if (in_byte == tof_pkg::B_SB) begin
          put        = 1'b1;
          phase_next = PH_SUB;
        end else begin
          put           = 1'b1;
          held_cmd_next = in_byte;
          phase_next    = PH_CMD;
        end
      end
      PH_CMD: begin
        if (in_byte == option_code) begin
          if (held_cmd == tof_pkg::B_WILL || held_cmd == tof_pkg::B_DO) begin
            opt_en_next = 1'b1;
            jkind       = tof_pkg::JOB_REPLY;
            jdo         = (held_cmd == tof_pkg::B_WILL);
          end else if (held_cmd == tof_pkg::B_WONT || held_cmd == tof_pkg::B_DONT) begin
            opt_en_next = 1'b0;
          end
        end
        hold_cnt_next = '0;
        phase_next    = PH_NORMAL;
      end
      PH_SUB: begin
        put = 1'b1;
        if (in_byte == tof_pkg::B_IAC) begin
          phase_next = PH_SUB_IAC;
        end
      end
      PH_SUB_IAC: begin
        if (in_byte == tof_pkg::B_SE) begin
          hold_cnt_next = '0;
          phase_next    = PH_NORMAL;
        end else begin
          put = 1'b1;
          if (in_byte != tof_pkg::B_IAC) begin
            phase_next = PH_SUB;
          end
        end
      end
      default: begin
        if (in_byte == tof_pkg::B_IAC) begin
          put        = 1'b1;
          put_base   = '0;
          phase_next = PH_IAC;
        end else begin
          jkind      = tof_pkg::JOB_DATA;
          phase_next = PH_NORMAL;
        end
      end
    endcase

    // keep the byte in the hold store while there is room
    room     = (put_base < tof_pkg::CNT_W'(tof_pkg::HOLD_DEPTH));
    ovf_work = ovf_seen | (put & ~room);
    if (put && room) begin
      hold_cnt_next = put_base + tof_pkg::CNT_W'(1);
    end

    // buffer end hands on an open sequence and returns to normal
    flush_cnt = '0;
    if (buffer_end && phase_next != PH_NORMAL) begin
      flush_cnt     = hold_cnt_next;
      hold_cnt_next = '0;
      phase_next    = PH_NORMAL;
    end

    ovf_seen_next = (phase_next == PH_NORMAL) ? 1'b0 : ovf_work;
  end

  // request to the back end
  assign job_push      = accept & ((jkind != tof_pkg::JOB_NONE) | buffer_end);
  assign job.jkind     = jkind;
  assign job.data      = jdata;
  assign job.reply_do  = jdo;
  assign job.buf_end   = buffer_end;
  assign job.flush_cnt = flush_cnt;
  assign job.option_on = opt_en_next;
  assign job.ovf       = ovf_work;

  // hold store write port
  assign hold_wr.en   = accept & put & room;
  assign hold_wr.addr = put_base[tof_pkg::ADDR_W-1:0];
  assign hold_wr.data = in_byte;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NORMAL;
      held_cmd <= '0;
      opt_en   <= 1'b0;
      hold_cnt <= '0;
      ovf_seen <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      held_cmd <= held_cmd_next;
      opt_en   <= opt_en_next;
      hold_cnt <= hold_cnt_next;
      ovf_seen <= ovf_seen_next;
    end
  end

  // flush in flight flag
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_busy <= 1'b0;
    end else if (job_push && flush_cnt != '0) begin
      flush_busy <= 1'b1;
    end else if (flush_done) begin
      flush_busy <= 1'b0;
    end
  end

  // tracked option number
  always_ff @(posedge clk) begin
    if (rst) begin
      option_code <= tof_pkg::OPT_RESET;
    end else if (cfg_valid) begin
      option_code <= cfg_data;
    end
  end

endmodule

>>> rtl/core/tof_jobq.sv
// two-entry request queue between front and back
module tof_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tof_pkg::job_t  wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output tof_pkg::job_t  rd_job
);

  tof_pkg::job_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slot[rptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/tof_back.sv
// back end: expands requests into result items, holds the hold store and result queue
module tof_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  tof_pkg::job_t      job,
  output logic               job_pop,
  output logic               flush_done,
  input  tof_pkg::hold_wr_t  hold_wr,
  output logic               empty,
  input  logic               pop,
  output tof_pkg::result_t   res
);

  typedef enum logic [4:0] {
    BK_HEAD  = 5'b00001,
    BK_R2    = 5'b00010,
    BK_R3    = 5'b00100,
    BK_FLUSH = 5'b01000,
    BK_MARK  = 5'b10000
  } bk_state_t;

  bk_state_t                 st, st_next;
  logic [tof_pkg::CNT_W-1:0] idx, idx_next;
  logic [7:0]                hold_mem [tof_pkg::HOLD_DEPTH];
  logic [7:0]                rd_data;

  tof_pkg::result_t          oq [2];
  logic                      owptr;
  logic                      orptr;
  logic [1:0]                ocnt;
  logic                      ofull;
  logic                      emit;
  logic                      go;
  logic                      opop;
  tof_pkg::result_t          r;

  // hold store, read data registered
  always_ff @(posedge clk) begin
    if (hold_wr.en) begin
      hold_mem[hold_wr.addr] <= hold_wr.data;
    end
    rd_data <= hold_mem[idx_next[tof_pkg::ADDR_W-1:0]];
  end

  assign ofull = (ocnt == 2'd2);
  assign go    = ~ofull;

  // result sequencer
  always_comb begin
    st_next     = st;
    idx_next    = idx;
    emit        = 1'b0;
    job_pop     = 1'b0;
    flush_done  = 1'b0;
    r.out_byte  = '0;
    r.kind      = tof_pkg::KIND_DATA;
    r.option_on = job.option_on;
    r.ovf       = job.ovf;
    r.last      = 1'b0;
    unique case (st)
      BK_HEAD: begin
        idx_next = '0;
        if (job_valid) begin
          if (job.jkind == tof_pkg::JOB_DATA) begin
            emit       = 1'b1;
            r.out_byte = job.data;
            r.last     = ~job.buf_end;
            if (go) begin
              if (job.buf_end) begin
                st_next = BK_MARK;
              end else begin
                job_pop = 1'b1;
              end
            end
          end else if (job.jkind == tof_pkg::JOB_REPLY) begin
            emit       = 1'b1;
            r.out_byte = tof_pkg::B_IAC;
            r.kind     = tof_pkg::KIND_REPLY;
            if (go) begin
              st_next = BK_R2;
            end
          end else if (job.flush_cnt != '0) begin
            // this cycle primes the store read of entry zero
            st_next = BK_FLUSH;
          end else begin
            emit   = 1'b1;
            r.kind = tof_pkg::KIND_MARK;
            r.last = 1'b1;
            if (go) begin
              job_pop = 1'b1;
            end
          end
        end
      end
      BK_R2: begin
        emit       = 1'b1;
        r.out_byte = job.reply_do ? tof_pkg::B_DO : tof_pkg::B_WILL;
        r.kind     = tof_pkg::KIND_REPLY;
        if (go) begin
          st_next = BK_R3;
        end
      end
      BK_R3: begin
        emit       = 1'b1;
        r.out_byte = job.data;
        r.kind     = tof_pkg::KIND_REPLY;
        r.last     = ~job.buf_end;
        if (go) begin
          if (job.buf_end) begin
            st_next = BK_MARK;
          end else begin
            job_pop = 1'b1;
            st_next = BK_HEAD;
          end
        end
      end
      BK_FLUSH: begin
        emit       = 1'b1;
        r.out_byte = rd_data;
        if (go) begin
          if (idx + tof_pkg::CNT_W'(1) == job.flush_cnt) begin
            st_next = BK_MARK;
          end else begin
            idx_next = idx + tof_pkg::CNT_W'(1);
          end
        end
      end
      BK_MARK: begin
        emit   = 1'b1;
        r.kind = tof_pkg::KIND_MARK;
        r.last = 1'b1;
        if (go) begin
          job_pop    = 1'b1;
          flush_done = (job.flush_cnt != '0);
          st_next    = BK_HEAD;
        end
      end
      default: begin
        st_next = BK_HEAD;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= BK_HEAD;
      idx <= '0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
    end
  end

  // result queue
  assign empty = (ocnt == 2'd0);
  assign res   = oq[orptr];
  assign opop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (emit && go) begin
      oq[owptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= 1'b0;
      orptr <= 1'b0;
      ocnt  <= 2'd0;
    end else begin
      if (emit && go) begin
        owptr <= ~owptr;
      end
      if (opop) begin
        orptr <= ~orptr;
      end
      if (emit && go && !opop) begin
        ocnt <= ocnt + 2'd1;
      end else if (opop && !(emit && go)) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/telnet_option_filter.sv
// top level of the inbound telnet option filter
//
//   channel   direction  handshake              payload
//   input     in         push / full            in_byte, buffer_end
//   result    out        empty / pop            out_byte, kind, option_on, hold_overflow, last
//   config    in         cfg_valid / cfg_ready  cfg_data (option number)
//
// one input byte per cycle while each byte causes at most one result and the receiver keeps popping.
// a negotiation reply gives three result items, a buffer end marker one more;
// a flush first starts the store read, then hands on one held byte per cycle unless stalled,
// and input is held off (full) until its marker has been queued.
// synchronous reset, no clearing pass; the hold store needs none.
// a two-entry request queue and a two-entry result queue let either side stall.
module telnet_option_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       buffer_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       option_on,
  output logic       hold_overflow,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  tof_pkg::job_t      fe_job;
  tof_pkg::job_t      be_job;
  tof_pkg::hold_wr_t  hold_wr;
  tof_pkg::result_t   res;
  logic               job_push;
  logic               jq_full;
  logic               job_valid;
  logic               job_pop;
  logic               flush_done;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // parser and classifier
  tof_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .buffer_end (buffer_end),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .jq_full    (jq_full),
    .flush_done (flush_done),
    .job_push   (job_push),
    .job        (fe_job),
    .hold_wr    (hold_wr)
  );

  // request queue
  tof_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (fe_job),
    .full     (jq_full),
    .rd_en    (job_pop),
    .rd_valid (job_valid),
    .rd_job   (be_job)
  );

  // result expansion
  tof_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (be_job),
    .job_pop    (job_pop),
    .flush_done (flush_done),
    .hold_wr    (hold_wr),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  // result fields
  assign out_byte      = res.out_byte;
  assign kind          = res.kind;
  assign option_on     = res.option_on;
  assign hold_overflow = res.ovf;
  assign last          = res.last;

endmodule

>>> rtl/core/tof_checker.sv
// port-level checks of the telnet option filter and their binding
module tof_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       last
);

  // reset leaves no results and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("filter not clear after reset");

  // only the three defined kinds appear
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind == tof_pkg::KIND_DATA || kind == tof_pkg::KIND_REPLY ||
                kind == tof_pkg::KIND_MARK))
    else $error("undefined result kind");

  // buffer end marker carries no byte and closes its request
  a_mark_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == tof_pkg::KIND_MARK) |-> (out_byte == 8'd0 && last))
    else $error("malformed buffer end marker");

  // a waiting result stays put until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(kind) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind telnet_option_filter tof_checker u_tof_checker (.*);

>>> tb/sv/testbench.sv
// self-checking testbench of the telnet option filter with its own byte-level predictor
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 8;

  // scanner state of the predictor
  typedef enum logic [4:0] {
    ST_NORMAL  = 5'b00001,
    ST_IAC     = 5'b00010,
    ST_CMD     = 5'b00100,
    ST_SUB     = 5'b01000,
    ST_SUB_IAC = 5'b10000
  } scan_state_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'd0;
  logic       buffer_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] res_byte;
  logic [1:0] res_kind;
  logic       res_option_on;
  logic       res_overflow;
  logic       res_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  // predictor copy of the block state and its register
  scan_state_t scan_state = ST_NORMAL;
  logic [7:0]  held_cmd = 8'd0;
  logic        opt_enabled = 1'b0;
  logic [7:0]  opt_code = tof_pkg::OPT_RESET;
  logic [7:0]  hold_mem [tof_pkg::HOLD_DEPTH];
  int          hold_cnt = 0;
  logic        ovf_seen = 1'b0;

  tof_pkg::result_t step_results[$];
  tof_pkg::result_t expected_results[$];
  tof_pkg::result_t want;
  int          errors = 0;
  int          bytes_sent = 0;
  bit          idle_on = 1'b1;
  int          pop_hold_off = 0;
  int          pop_stall = 0;

  telnet_option_filter dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .buffer_end    (buffer_end),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (res_byte),
    .kind          (res_kind),
    .option_on     (res_option_on),
    .hold_overflow (res_overflow),
    .last          (res_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run time limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic void add_result(input logic [7:0] b, input logic [1:0] k);
    step_results.push_back('{out_byte: b, kind: k, option_on: 1'b0, ovf: 1'b0, last: 1'b0});
  endfunction

  function automatic void hold_byte(input logic [7:0] b);
    if (hold_cnt < tof_pkg::HOLD_DEPTH) begin
      hold_mem[hold_cnt] = b;
      hold_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  // expected results of one accepted request
  function automatic void filter_byte(input logic [7:0] b, input logic e);
    logic ovf_now;
    step_results.delete();
    case (scan_state)
      ST_IAC: begin
        if (b == tof_pkg::B_IAC) begin
          add_result(tof_pkg::B_IAC, tof_pkg::KIND_DATA);
          hold_cnt = 0;
          scan_state = ST_NORMAL;
        end else if (b == tof_pkg::B_SB) begin
          hold_byte(b);
          scan_state = ST_SUB;
        end else begin
          hold_byte(b);
          held_cmd = b;
          scan_state = ST_CMD;
        end
      end
      ST_CMD: begin
        if (b == opt_code) begin
          if (held_cmd == tof_pkg::B_WILL || held_cmd == tof_pkg::B_DO) begin
            opt_enabled = 1'b1;
            add_result(tof_pkg::B_IAC, tof_pkg::KIND_REPLY);
            add_result((held_cmd == tof_pkg::B_WILL) ? tof_pkg::B_DO : tof_pkg::B_WILL,
                       tof_pkg::KIND_REPLY);
            add_result(b, tof_pkg::KIND_REPLY);
          end else if (held_cmd == tof_pkg::B_WONT || held_cmd == tof_pkg::B_DONT) begin
            opt_enabled = 1'b0;
          end
        end
        hold_cnt = 0;
        scan_state = ST_NORMAL;
      end
      ST_SUB: begin
        hold_byte(b);
        if (b == tof_pkg::B_IAC) scan_state = ST_SUB_IAC;
      end
      ST_SUB_IAC: begin
        if (b == tof_pkg::B_SE) begin
          hold_cnt = 0;
          scan_state = ST_NORMAL;
        end else begin
          hold_byte(b);
          if (b != tof_pkg::B_IAC) scan_state = ST_SUB;
        end
      end
      default: begin
        if (b == tof_pkg::B_IAC) begin
          hold_cnt = 0;
          hold_byte(b);
          scan_state = ST_IAC;
        end else begin
          add_result(b, tof_pkg::KIND_DATA);
          scan_state = ST_NORMAL;
        end
      end
    endcase

    // buffer end hands on an open sequence, then the marker
    if (e) begin
      if (scan_state != ST_NORMAL) begin
        for (int i = 0; i < hold_cnt; i++) add_result(hold_mem[i], tof_pkg::KIND_DATA);
        hold_cnt = 0;
        scan_state = ST_NORMAL;
      end
      add_result(8'd0, tof_pkg::KIND_MARK);
    end

    ovf_now = ovf_seen;
    if (scan_state == ST_NORMAL) ovf_seen = 1'b0;

    foreach (step_results[i]) begin
      step_results[i].option_on = opt_enabled;
      step_results[i].ovf       = ovf_now;
      step_results[i].last      = (i == step_results.size() - 1);
      expected_results.push_back(step_results[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_byte %0h kind %0d", res_byte, res_kind);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", want.out_byte, res_byte);
        check_field("kind", 8'(want.kind), 8'(res_kind));
        check_field("option_on", 8'(want.option_on), 8'(res_option_on));
        check_field("hold_overflow", 8'(want.ovf), 8'(res_overflow));
        check_field("last", 8'(want.last), 8'(res_last));
      end
    end
    if (pop_hold_off != 0) begin
      pop <= 1'b0;
      pop_hold_off <= pop_hold_off - 1;
    end else if (pop_stall != 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_stall <= $urandom_range(0, 14);
    end else begin
      pop <= 1'b1;
    end
  end

  // one input request, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b, input logic e = 1'b0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push       <= 1'b1;
    in_byte    <= b;
    buffer_end <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    filter_byte(b, e);
    bytes_sent++;
  endtask

  task automatic negotiate(input logic [7:0] cmd, input logic [7:0] opt,
                           input logic e = 1'b0);
    send_byte(tof_pkg::B_IAC);
    send_byte(cmd);
    send_byte(opt, e);
  endtask

  // subnegotiation with random body, closed by IAC SE or cut by a buffer end
  task automatic subnegotiate(input int len, input bit close, input logic e);
    logic [7:0] b;
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_SB, !close && len == 0 && e);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 254));
      if ($urandom_range(0, 7) == 0) begin
        send_byte(tof_pkg::B_IAC);
        if ($urandom_range(0, 1) == 0) b = tof_pkg::B_IAC;
      end
      send_byte(b, !close && i == len - 1 && e);
    end
    if (close) begin
      send_byte(tof_pkg::B_IAC);
      send_byte(tof_pkg::B_SE, e);
    end
  endtask

  // stop sending until every expected result is out and the block settles
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_option(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    opt_code = v;
  endtask

  task automatic test_plain_data();
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'hF0);
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_IAC);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_negotiation();
    negotiate(tof_pkg::B_WILL, opt_code);
    negotiate(tof_pkg::B_DONT, opt_code);
    negotiate(tof_pkg::B_DO, opt_code, 1'b1);
    negotiate(8'hF1, opt_code ^ 8'h01);
  endtask

  // escaped IAC inside, then exactly one byte after the close
  task automatic test_subnegotiation();
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_SB);
    send_byte(8'd24);
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_SE);
    send_byte(8'hA5, 1'b1);
  endtask

  // buffer ends inside open sequences
  task automatic test_buffer_end_flush();
    send_byte(tof_pkg::B_IAC, 1'b1);
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_WILL, 1'b1);
    subnegotiate(2, 1'b0, 1'b1);
  endtask

  task automatic test_option_config();
    write_option(8'h00);
    negotiate(tof_pkg::B_WILL, 8'h00);
    negotiate(tof_pkg::B_WONT, 8'h00);
    write_option(8'hFF);
    negotiate(tof_pkg::B_DO, 8'hFF);
    negotiate(tof_pkg::B_DONT, 8'hFF, 1'b1);
    write_option(8'($urandom_range(0, 255)));
  endtask

  // subnegotiation longer than the hold store, cut by a buffer end
  task automatic test_hold_overflow();
    send_byte(tof_pkg::B_IAC);
    send_byte(tof_pkg::B_SB);
    for (int i = 0; i < tof_pkg::HOLD_DEPTH + 2; i++)
      send_byte(8'($urandom_range(0, 254)), i == tof_pkg::HOLD_DEPTH + 1);
    send_byte(8'h01);
  endtask

  // receiver holds off while replies pile up, then the sender waits
  task automatic test_backpressure();
    pop_hold_off <= 300;
    for (int i = 0; i < 5; i++)
      negotiate((i % 2) ? tof_pkg::B_DO : tof_pkg::B_WILL, opt_code, i % 5 == 4);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    logic [7:0]  cmd;
    int          len;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) write_option(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0, 1, 2: send_byte(8'($urandom_range(0, 254)), $urandom_range(0, 5) == 0);
        3: begin
          send_byte(tof_pkg::B_IAC);
          send_byte(tof_pkg::B_IAC, $urandom_range(0, 3) == 0);
        end
        4, 5: begin
          case ($urandom_range(0, 4))
            0: cmd = tof_pkg::B_WILL;
            1: cmd = tof_pkg::B_DO;
            2: cmd = tof_pkg::B_WONT;
            3: cmd = tof_pkg::B_DONT;
            default: cmd = 8'($urandom_range(0, 255));
          endcase
          negotiate(cmd, ($urandom_range(0, 3) != 0) ? opt_code : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
        end
        6, 7: begin
          len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
          if ($urandom_range(0, 3) == 0) subnegotiate(len, 1'b0, 1'b1);
          else subnegotiate(len, 1'b1, $urandom_range(0, 3) == 0);
        end
        8: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: begin
          send_byte(tof_pkg::B_IAC);
          send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    wait_drained();
    idle_on = 1'b0;
    test_random_traffic(8);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_plain_data();
    test_negotiation();
    test_subnegotiation();
    test_buffer_end_flush();
    test_option_config();
    test_hold_overflow();
    test_backpressure();
    test_random_traffic(8);
    test_steady_stream();
    wait_drained();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
